// ===== sv/efd_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the escaped frame deframer.
package efd_pkg;

    // Framing bytes on the serial link
    localparam logic [7:0] START_CODE = 8'd253;
    localparam logic [7:0] END_CODE   = 8'd254;
    localparam logic [7:0] ESC_CODE   = 8'd255;

    // CRC-16 generator polynomial and the reset value of crc_init
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT_RST = 16'hFFFF;

    // Result event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_STORE = 2'd1;
    localparam logic [1:0] EV_GOOD  = 2'd2;
    localparam logic [1:0] EV_BAD   = 2'd3;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // Operation handed from the front to the back
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_START = 2'd1,
        OP_STORE = 2'd2,
        OP_END   = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
    } t_op;

    // Feed one byte into a CRC-16, MSB first, no reflection
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/efd_front.sv =====
// Front end: tracks framing and escapes, turns each received byte into one operation.
module efd_front
    import efd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output t_op        o_op
);

    logic r_in_frame, n_in_frame;
    logic r_esc,      n_esc;

    // Classify the byte against the framing state
    always_comb begin
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        o_op.kind  = OP_NONE;
        o_op.data  = i_rx_byte;
        if (r_esc) begin
            n_esc = 1'b0;
            if (i_rx_byte inside {START_CODE, END_CODE, ESC_CODE}) begin
                o_op.kind = OP_STORE;
            end
        end else if (i_rx_byte == START_CODE) begin
            n_in_frame = 1'b1;
            o_op.kind  = OP_START;
        end else if (!r_in_frame) begin
            o_op.kind = OP_NONE;
        end else if (i_rx_byte == END_CODE) begin
            n_in_frame = 1'b0;
            o_op.kind  = OP_END;
        end else if (i_rx_byte == ESC_CODE) begin
            n_esc = 1'b1;
        end else begin
            o_op.kind = OP_STORE;
        end
    end

    // Advance framing state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
        end else if (i_accept) begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
        end
    end

endmodule

// ===== sv/efd_queue.sv =====
// Short register queue of operations between the front and the back.
module efd_queue
    import efd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_op  o_op
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_op           r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd_ptr];

    // Hold payload entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== sv/efd_back.sv =====
// Back end: byte count, delay line and CRC check; drives the registered result word.
module efd_back
    import efd_pkg::*;
#(
    parameter int BUF_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_crc_init,
    input  logic        i_q_valid,
    input  t_op         i_op,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event,
    output logic [7:0]  o_data,
    output logic [5:0]  o_count
);

    localparam int CW = $clog2(BUF_SIZE);
    localparam int WW = (CW > 6) ? CW : 6;

    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_crc,   n_crc;
    logic [15:0]   r_last,  n_last;
    logic          r_valid;
    logic [1:0]    r_event, n_event;
    logic [7:0]    r_data,  n_data;
    logic [5:0]    r_ocnt,  n_ocnt;

    logic [CW-1:0] len;
    logic [WW-1:0] count_ext;
    logic [WW-1:0] len_ext;
    logic          two_held;

    assign o_pop     = i_q_valid && (!r_valid || i_ready);
    assign len       = r_count - CW'(2);
    assign count_ext = WW'(r_count);
    assign len_ext   = WW'(len);
    assign two_held  = (r_count >= CW'(2));

    // Carry out one operation
    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        n_last  = r_last;
        n_event = EV_NONE;
        n_data  = 8'd0;
        n_ocnt  = 6'd0;
        case (i_op.kind)
            OP_START: begin
                n_count = '0;
                n_crc   = i_crc_init;
            end
            OP_STORE: begin
                n_event = EV_STORE;
                n_data  = i_op.data;
                n_ocnt  = count_ext[5:0];
                if (two_held) begin
                    n_crc = crc_feed(r_crc, r_last[15:8]);
                end
                n_last = {r_last[7:0], i_op.data};
                // wrap at buffer size and restart the CRC
                if (r_count == CW'(BUF_SIZE - 1)) begin
                    n_count = '0;
                    n_crc   = i_crc_init;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_END: begin
                if (two_held && r_last == r_crc) begin
                    n_event = EV_GOOD;
                    n_ocnt  = len_ext[5:0];
                end else begin
                    n_event = EV_BAD;
                end
            end
            default: begin
                n_event = EV_NONE;
            end
        endcase
    end

    // Advance state and load the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT_RST;
            r_last  <= 16'd0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count <= n_count;
                r_crc   <= n_crc;
                r_last  <= n_last;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event <= n_event;
            r_data  <= n_data;
            r_ocnt  <= n_ocnt;
        end
    end

    assign o_valid = r_valid;
    assign o_event = r_event;
    assign o_data  = r_data;
    assign o_count = r_ocnt;

endmodule

// ===== sv/escaped_frame_deframer_crc16_core.sv =====
// Top level of the byte-stuffed frame deframer with CRC-16 check.
//
//  Channel   | Direction | Handshake               | Payload
//  ----------+-----------+-------------------------+------------------------------------
//  s_axis    | in        | tvalid / tready         | tdata[7:0] rx_byte
//  m_axis    | out       | tvalid / tready         | tuser event_res, tdata data_byte,count
//  apb       | in        | psel / penable / pready | crc_init at address 0
//
// One word per cycle sustained while m_axis_tready is high; a result word passes through
// the queue and the output register. The front registers framing state, a two-entry queue
// decouples it from the back, whose byte-wide CRC update feeds the output register.
// Reset (synchronous, active low) empties the queue and output, clears framing state
// and loads crc_init with 0xFFFF. A stalled output fills the queue, then drops s_axis_tready.
module escaped_frame_deframer_crc16_core
    import efd_pkg::*;
#(
    parameter int BUF_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // stream output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [13:8] count, [15:14] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] event_res
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_crc_init_val;
    logic        accept;
    t_op         front_op;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    t_op         q_op;
    logic [7:0]  out_data;
    logic [5:0]  out_count;

    // Configuration register write and read-back
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_init_val <= CRC_INIT_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_crc_init_val <= pwdata[15:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_crc_init_val};

    // Accept a word whenever the queue has room
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    efd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (s_axis_tdata),
        .o_op      (front_op)
    );

    efd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_op    (q_op)
    );

    efd_back #(
        .BUF_SIZE (BUF_SIZE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_crc_init (r_crc_init_val),
        .i_q_valid  (q_valid),
        .i_op       (q_op),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_event    (m_axis_tuser),
        .o_data     (out_data),
        .o_count    (out_count)
    );

    // Pack the result word, upper pad bits held low
    assign m_axis_tdata = {2'b00, out_count, out_data};

endmodule

// ===== tb/escaped_frame_deframer_crc16_checker.sv =====
// Result checker for the escaped frame deframer: tracks framing state and compares output words.
module escaped_frame_deframer_crc16_checker
    import efd_pkg::*;
#(
    parameter int         BUF_WORDS     = 64,
    parameter logic [2:0] ADDR_CRC_INIT = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream as seen at the block
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // output stream as seen at the block
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [7:0] data_byte, [13:8] count, [15:14] zero
    input  logic [1:0]  i_m_tuser,   // [1:0] event_res
    // register port as seen at the block
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_words_owed
);

    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] data;
        logic [5:0] pos;
    } t_result_word;

    // Words the block still owes, oldest first
    t_result_word owed_q[$];

    // Shadow of the deframer state
    logic [15:0] init_val;
    logic [15:0] crc_run;
    logic [15:0] tail_pair;
    logic        in_frame;
    logic        esc_armed;
    int unsigned pos;
    int          fails = 0;

    assign o_fail_count = fails;

    task automatic report_miss(input string what, input int got, input int want);
        fails++;
        if (fails <= 60) begin
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
        end
    endtask

    // Shift one byte through the CRC-16 register, MSB first
    function automatic logic [15:0] crc_advance(input logic [15:0] r, input logic [7:0] d);
        logic [15:0] x;
        logic        fb;
        x = r;
        for (int i = 7; i >= 0; i--) begin
            fb = x[15] ^ d[i];
            x  = {x[14:0], 1'b0};
            if (fb) begin
                x = x ^ CRC_POLY;
            end
        end
        return x;
    endfunction

    // Store a byte: the byte leaving the two-byte delay line enters the CRC
    task automatic keep_byte(input logic [7:0] c, inout t_result_word w);
        w.ev   = EV_STORE;
        w.data = c;
        w.pos  = 6'(pos);
        if (pos >= 2) begin
            crc_run = crc_advance(crc_run, tail_pair[15:8]);
        end
        tail_pair = {tail_pair[7:0], c};
        pos++;
        // wrap a full buffer and restart the check as if a new frame began
        if (pos >= BUF_WORDS) begin
            pos     = 0;
            crc_run = init_val;
        end
    endtask

    // Work out the word caused by one received byte
    task automatic deframe(input logic [7:0] c);
        t_result_word w;
        w = '0;
        if (esc_armed) begin
            esc_armed = 1'b0;
            if (c inside {START_CODE, END_CODE, ESC_CODE}) begin
                keep_byte(c, w);
            end
        end else if (c == START_CODE) begin
            in_frame = 1'b1;
            pos      = 0;
            crc_run  = init_val;
        end else if (!in_frame) begin
            // drop bytes outside a frame
            w.ev = EV_NONE;
        end else if (c == END_CODE) begin
            in_frame = 1'b0;
            if (pos >= 2 && tail_pair == crc_run) begin
                w.ev  = EV_GOOD;
                w.pos = 6'(pos - 2);
            end else begin
                w.ev = EV_BAD;
            end
        end else if (c == ESC_CODE) begin
            esc_armed = 1'b1;
        end else begin
            keep_byte(c, w);
        end
        owed_q.push_back(w);
    endtask

    always @(posedge i_clk) begin
        t_result_word w;
        if (!i_rst_n) begin
            init_val  = CRC_INIT_RST;
            crc_run   = CRC_INIT_RST;
            tail_pair = '0;
            in_frame  = 1'b0;
            esc_armed = 1'b0;
            pos       = 0;
            owed_q.delete();
        end else begin
            // compare an accepted output word with the oldest one owed
            if (i_m_tvalid && i_m_tready) begin
                if (owed_q.size() == 0) begin
                    report_miss("unowed word, event_res", i_m_tuser, -1);
                end else begin
                    w = owed_q.pop_front();
                    if (i_m_tuser !== w.ev) begin
                        report_miss("event_res", i_m_tuser, w.ev);
                    end
                    if (i_m_tdata[7:0] !== w.data) begin
                        report_miss("data_byte", i_m_tdata[7:0], w.data);
                    end
                    if (i_m_tdata[13:8] !== w.pos) begin
                        report_miss("count", i_m_tdata[13:8], w.pos);
                    end
                    if (i_m_tdata[15:14] !== 2'b00) begin
                        report_miss("tdata padding", i_m_tdata[15:14], 0);
                    end
                end
            end
            // predict the word for an accepted input byte
            if (i_s_tvalid && i_s_tready) begin
                deframe(i_s_tdata);
            end
            // track register writes, check readback
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_CRC_INIT) begin
                if (i_pwrite) begin
                    init_val = i_pwdata[15:0];
                end else if (i_prdata !== {16'h0000, init_val}) begin
                    report_miss("crc_init readback", i_prdata, init_val);
                end
            end
        end
        o_words_owed <= owed_q.size();
    end

endmodule

// ===== tb/escaped_frame_deframer_crc16_core_test.sv =====
// Stimulus and verdict for the escaped frame deframer: frames, line noise and crc_init writes.
module escaped_frame_deframer_crc16_core_test;
    import efd_pkg::*;

    localparam int         BUF_WORDS     = 64;
    localparam logic [2:0] ADDR_CRC_INIT = 3'd0;
    localparam logic [2:0] ADDR_SPARE    = 3'd4;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         PHASE_WORDS   = 360;

    typedef logic [7:0] t_byte_q[$];

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [7:0] data_byte, [13:8] count, [15:14] zero
    logic [1:0]  m_axis_tuser;         // [1:0] event_res
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        steady        = 1'b0;   // no idling on either side
    logic [15:0] crc_seed      = CRC_INIT_RST;
    int          rx_words      = 0;
    int          fail_count;
    int          words_owed;

    escaped_frame_deframer_crc16_core #(
        .BUF_SIZE(BUF_WORDS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    escaped_frame_deframer_crc16_checker #(
        .BUF_WORDS    (BUF_WORDS),
        .ADDR_CRC_INIT(ADDR_CRC_INIT)
    ) result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_words_owed(words_owed)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Stall the output side at random
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 23);
    end

    // End the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // CRC-16 over one byte, used to build frames with a valid check word
    function automatic logic [15:0] crc16_next(input logic [15:0] r, input logic [7:0] d);
        logic [15:0] x;
        x = r ^ {d, 8'h00};
        repeat (8) x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
        return x;
    endfunction

    // Random byte with the framing codes well represented
    function automatic logic [7:0] link_byte();
        if ($urandom_range(4) == 0) begin
            return 8'(START_CODE + $urandom_range(2));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic t_byte_q rand_payload(input int len);
        t_byte_q q;
        q = {};
        repeat (len) q.push_back(link_byte());
        return q;
    endfunction

    // Offer one word, with random gaps, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rx_words++;
    endtask

    // Escape any framing code so it lands in the payload
    task automatic stuff_byte(input logic [7:0] b);
        if (b inside {START_CODE, END_CODE, ESC_CODE}) begin
            send_byte(ESC_CODE);
        end
        send_byte(b);
    endtask

    // Send a frame: start, optional buffer-filling prefix, payload, check word, optional end
    task automatic send_frame(input t_byte_q payload, input bit wrap_first, input bit corrupt,
                              input bit close);
        t_byte_q     body;
        logic [15:0] crc;
        int          k;
        int          first;
        body  = {};
        crc   = crc_seed;
        first = 0;
        if (wrap_first) begin
            body  = rand_payload(BUF_WORDS);
            first = BUF_WORDS;
        end
        foreach (payload[i]) begin
            crc = crc16_next(crc, payload[i]);
            body.push_back(payload[i]);
        end
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        // flip one bit after the wrap point so the check must fail
        if (corrupt) begin
            k       = first + $urandom_range(payload.size() + 1);
            body[k] = body[k] ^ (8'd1 << $urandom_range(7));
        end
        send_byte(START_CODE);
        foreach (body[i]) begin
            // now and then an escape before a plain byte, which drops it
            if ($urandom_range(99) < 4) begin
                send_byte(ESC_CODE);
                send_byte(8'($urandom_range(252)));
            end
            stuff_byte(body[i]);
        end
        if (close) begin
            send_byte(END_CODE);
        end
    endtask

    // Drop valid and wait until every owed word has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (words_owed != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_crc_init(input logic [15:0] v);
        settle();
        apb_access(1'b1, ADDR_CRC_INIT, {16'($urandom), v});
        apb_access(1'b0, ADDR_CRC_INIT, '0);
        crc_seed = v;
    endtask

    // Pick one frame shape: mostly well formed, the rest broken or noise
    task automatic random_frame();
        int         roll;
        int         len;
        int         words_at_start;
        logic [7:0] v;
        roll = $urandom_range(99);
        len  = ($urandom_range(7) == 0) ? $urandom_range(BUF_WORDS - 5) : $urandom_range(12);
        if (roll < 62) begin
            send_frame(rand_payload(len), 1'b0, 1'b0, 1'b1);
        end else if (roll < 70) begin
            send_frame(rand_payload(len), 1'b1, 1'b0, 1'b1);
        end else if (roll < 80) begin
            send_frame(rand_payload(len), $urandom_range(3) == 0, 1'b1, 1'b1);
        end else if (roll < 86) begin
            // line noise between frames does not count toward the volume
            words_at_start = rx_words;
            repeat ($urandom_range(1, 4)) begin
                v = 8'($urandom_range(255));
                if (v == START_CODE) begin
                    v = ESC_CODE;
                end
                send_byte(v);
            end
            rx_words = words_at_start;
        end else if (roll < 93) begin
            // leave the frame open, sometimes with an escape waiting on the next start
            send_frame(rand_payload(len), 1'b0, 1'b0, 1'b0);
            if ($urandom_range(1) == 0) begin
                send_byte(ESC_CODE);
            end
        end else begin
            // too short for a check word, also right at a buffer wrap
            case ($urandom_range(3))
                0: begin
                    len = 0;
                end
                1: begin
                    len = 1;
                end
                2: begin
                    len = BUF_WORDS;
                end
                default: begin
                    len = BUF_WORDS + 1;
                end
            endcase
            send_byte(START_CODE);
            repeat (len) stuff_byte(link_byte());
            send_byte(END_CODE);
        end
    endtask

    initial begin
        t_byte_q     pl;
        logic [15:0] seeds [5];
        int          ph;
        int          goal;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, ADDR_CRC_INIT, '0);

        // bytes outside a frame are ignored, framing codes included
        send_byte(8'h00);
        send_byte(END_CODE);
        send_byte(8'h7F);
        send_byte(8'h80);
        // frames too short to hold a check word
        send_byte(START_CODE);
        send_byte(END_CODE);
        send_byte(START_CODE);
        send_byte(8'h00);
        send_byte(END_CODE);
        // empty payload; the check word itself needs escaping
        pl = {};
        send_frame(pl, 1'b0, 1'b0, 1'b1);
        pl = '{8'h00, 8'hFF, 8'hFD, 8'hFE, 8'h01};
        send_frame(pl, 1'b0, 1'b0, 1'b1);
        // escape drops a plain byte, keeps end and start; a bare start restarts
        send_byte(START_CODE);
        send_byte(ESC_CODE);
        send_byte(8'h41);
        send_byte(ESC_CODE);
        send_byte(END_CODE);
        send_byte(ESC_CODE);
        send_byte(START_CODE);
        send_byte(START_CODE);
        send_byte(8'h10);
        send_byte(END_CODE);
        // broken check word
        pl = '{8'h55, 8'hAA};
        send_frame(pl, 1'b0, 1'b1, 1'b1);
        // zero seed; a write to an unused address leaves it alone
        set_crc_init(16'h0000);
        apb_access(1'b1, ADDR_SPARE, 32'h0000_1234);
        apb_access(1'b0, ADDR_CRC_INIT, '0);
        pl = '{8'h31, 8'h32, 8'h33};
        send_frame(pl, 1'b0, 1'b0, 1'b1);

        // random frames under several seeds, one phase without idling
        seeds = '{16'h1D0F, 16'hFFFF, 16'($urandom), 16'h0000, 16'($urandom)};
        for (ph = 0; ph < 5; ph++) begin
            set_crc_init(seeds[ph]);
            steady <= (ph == 2);
            goal = rx_words + PHASE_WORDS;
            while (rx_words < goal) random_frame();
        end

        settle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
